// File: design/mcsr_pkg.sv
`default_nettype none
package mcsr_pkg;

  localparam int NUM_CONTEXTS = 4;
  localparam int MAX_SEGMENTS = 8;

  localparam int CTX_IDX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int MASK_W    = 2 * MAX_SEGMENTS;
  localparam int POS_W     = $clog2(MASK_W);
  localparam int MEM_DEPTH = NUM_CONTEXTS * MAX_SEGMENTS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [3:0] PERM_READ_ONLY  = 4'd0;
  localparam logic [3:0] PERM_READ_WRITE = 4'd1;

  typedef enum logic [1:0] {
    KIND_RO    = 2'd0,
    KIND_RW    = 2'd1,
    KIND_OTHER = 2'd2
  } perm_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_LOAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic latch;
    logic upd;
    logic ld_empty;
    logic rd;
    logic ld_byte;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic has_bytes;
    logic out_last;
  } status_t;

  function automatic perm_kind_e perm_kind_of(input logic [3:0] perm);
    perm_kind_e kind;
    if (perm == PERM_READ_ONLY) begin
      kind = KIND_RO;
    end else if (perm == PERM_READ_WRITE) begin
      kind = KIND_RW;
    end else begin
      kind = KIND_OTHER;
    end
    return kind;
  endfunction

endpackage
`default_nettype wire

// File: design/mcsr_ctrl.sv
`default_nettype none
module mcsr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire mcsr_pkg::status_t status_i,
  output mcsr_pkg::cmd_t        cmd_o
);
  import mcsr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!status_i.complete) begin
          state_d = ST_IDLE;
        end else if (status_i.has_bytes) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = status_i.out_last ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.upd      = 1'b1;
        cmd_o.ld_empty = status_i.complete & ~status_i.has_bytes;
      end
      ST_READ: cmd_o.rd = 1'b1;
      ST_LOAD: cmd_o.ld_byte = 1'b1;
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/mcsr_dp.sv
`default_nettype none
module mcsr_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mcsr_pkg::cmd_t    cmd_i,
  output mcsr_pkg::status_t      status_o,
  input  wire logic [1:0]        msg_id_i,
  input  wire logic [2:0]        total_segments_i,
  input  wire logic [2:0]        seq_num_i,
  input  wire logic [3:0]        perm_code_i,
  input  wire logic [7:0]        first_char_i,
  input  wire logic [7:0]        second_char_i,
  output logic [1:0]             done_msg_id_o,
  output logic [7:0]             name_char_o,
  output logic                   name_empty_o,
  output logic [3:0]             perm_out_o,
  output logic [1:0]             perm_kind_o,
  output logic                   last_o
);
  import mcsr_pkg::*;

  // latched input word
  logic [1:0] id_q;
  logic [2:0] tot_q;
  logic [2:0] seq_q;
  logic [3:0] perm_q;
  logic [7:0] c1_q;
  logic [7:0] c2_q;

  // context state
  logic [NUM_CONTEXTS-1:0]                   active_q;
  logic [NUM_CONTEXTS-1:0][2:0]              total_q;
  logic [NUM_CONTEXTS-1:0][3:0]              perm_reg_q;
  logic [NUM_CONTEXTS-1:0][MAX_SEGMENTS-1:0] seen_q;
  logic [NUM_CONTEXTS-1:0][3:0]              cnt_q;
  // per segment nonzero flags, bit 0 first byte
  logic [NUM_CONTEXTS-1:0][MAX_SEGMENTS-1:0][1:0] nz_q;

  logic [15:0] seg_mem [MEM_DEPTH];
  logic [15:0] rdata_q;

  logic [MASK_W-1:0]    mask_q;
  logic [CTX_IDX_W-1:0] emit_ctx_q;
  logic [1:0]           emit_id_q;
  logic [3:0]           emit_perm_q;
  logic                 half_q;

  logic [7:0] char_q;
  logic       empty_q;
  logic       last_q;

  // update path
  logic [CTX_IDX_W-1:0]    ctx;
  logic [SEG_IDX_W-1:0]    seg;
  logic                    in_range;
  logic                    act;
  logic [2:0]              new_total;
  logic [3:0]              new_perm;
  logic [MAX_SEGMENTS-1:0] base_seen;
  logic [MAX_SEGMENTS-1:0] new_seen;
  logic [3:0]              base_cnt;
  logic [3:0]              new_cnt;
  logic                    wr;
  logic                    complete;
  logic [MASK_W-1:0]       new_mask;
  logic [ADDR_W-1:0]       wr_addr;

  function automatic logic second_char_nz(input logic [7:0] c);
    return c != 8'd0;
  endfunction

  assign ctx      = id_q[CTX_IDX_W-1:0];
  assign seg      = seq_q[SEG_IDX_W-1:0];
  assign in_range = {1'b0, id_q} < 3'(NUM_CONTEXTS);
  assign act      = active_q[ctx];
  assign wr_addr  = ADDR_W'(ADDR_W'(ctx) * ADDR_W'(MAX_SEGMENTS) + ADDR_W'(seg));

  always_comb begin
    logic [1:0] nz;
    new_total = act ? total_q[ctx] : 3'd0;
    new_perm  = act ? perm_reg_q[ctx] : 4'd0;
    base_seen = act ? seen_q[ctx] : '0;
    base_cnt  = act ? cnt_q[ctx] : 4'd0;
    if (seq_q == 3'd0) begin
      new_total = tot_q;
      new_perm  = perm_q;
    end
    wr       = ({1'b0, seq_q} < 4'(MAX_SEGMENTS)) && !base_seen[seg];
    new_seen = base_seen;
    if (wr) new_seen[seg] = 1'b1;
    new_cnt  = base_cnt + {3'd0, wr};
    complete = in_range && (new_total != 3'd0) && (new_cnt == {1'b0, new_total});
    for (int s = 0; s < MAX_SEGMENTS; s++) begin
      if (wr && (s == int'(seg))) begin
        nz = {second_char_nz(c2_q), second_char_nz(c1_q)};
      end else begin
        nz = nz_q[ctx][s];
      end
      new_mask[2*s]   = new_seen[s] && (s < int'(new_total)) && nz[0];
      new_mask[2*s+1] = new_seen[s] && (s < int'(new_total)) && nz[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      id_q   <= msg_id_i;
      tot_q  <= total_segments_i;
      seq_q  <= seq_num_i;
      perm_q <= perm_code_i;
      c1_q   <= first_char_i;
      c2_q   <= second_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      total_q    <= '0;
      perm_reg_q <= '0;
      seen_q     <= '0;
      cnt_q      <= '0;
    end else if (cmd_i.upd && in_range) begin
      active_q[ctx]   <= ~complete;
      total_q[ctx]    <= complete ? 3'd0 : new_total;
      perm_reg_q[ctx] <= new_perm;
      seen_q[ctx]     <= complete ? '0 : new_seen;
      cnt_q[ctx]      <= complete ? 4'd0 : new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && in_range && wr) begin
      nz_q[ctx][seg]   <= {c2_q != 8'd0, c1_q != 8'd0};
      seg_mem[wr_addr] <= {c1_q, c2_q};
    end
  end

  // emit path
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    pos = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask_q[i]) pos = POS_W'(i);
    end
  end

  assign rd_addr = ADDR_W'(ADDR_W'(emit_ctx_q) * ADDR_W'(MAX_SEGMENTS) + ADDR_W'(pos >> 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && complete) begin
      mask_q      <= new_mask;
      emit_ctx_q  <= ctx;
      emit_id_q   <= id_q;
      emit_perm_q <= new_perm;
    end else if (cmd_i.rd) begin
      mask_q[pos] <= 1'b0;
      half_q      <= pos[0];
      rdata_q     <= seg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_empty) begin
      done_msg_id_o <= id_q;
      char_q        <= 8'd0;
      empty_q       <= 1'b1;
      perm_out_o    <= new_perm;
      perm_kind_o   <= perm_kind_of(new_perm);
      last_q        <= 1'b1;
    end else if (cmd_i.ld_byte) begin
      done_msg_id_o <= emit_id_q;
      char_q        <= half_q ? rdata_q[7:0] : rdata_q[15:8];
      empty_q       <= 1'b0;
      perm_out_o    <= emit_perm_q;
      perm_kind_o   <= perm_kind_of(emit_perm_q);
      last_q        <= (mask_q == '0);
    end
  end

  assign name_char_o  = char_q;
  assign name_empty_o = empty_q;
  assign last_o       = last_q;

  assign status_o.complete  = complete;
  assign status_o.has_bytes = (new_mask != '0);
  assign status_o.out_last  = last_q;

endmodule
`default_nettype wire

// File: design/multi_context_segment_reassembler_unit.sv
// update: a segment word is latched in ST_IDLE and applied in ST_UPDATE in the cycle after, so in_ready_o
//   drops until ST_UPDATE returns to ST_IDLE, which it does when no name ends; no word is taken while one is applied
// completion: the empty-name item is loaded during the update and shown in the cycle after; otherwise each byte
//   passes through segment memory read, output load and output, plus any output stall
// reset: rst_ni clears the context active flags, totals, counts and maps at once; no clearing pass
`default_nettype none
module multi_context_segment_reassembler_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] msg_id_i,
  input  wire logic [2:0] total_segments_i,
  input  wire logic [2:0] seq_num_i,
  input  wire logic [3:0] perm_code_i,
  input  wire logic [7:0] first_char_i,
  input  wire logic [7:0] second_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      done_msg_id_o,
  output logic [7:0]      name_char_o,
  output logic            name_empty_o,
  output logic [3:0]      perm_out_o,
  output logic [1:0]      perm_kind_o,
  output logic            last_o
);
  import mcsr_pkg::*;

  cmd_t    cmd;
  status_t status;

  mcsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mcsr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .msg_id_i         (msg_id_i),
    .total_segments_i (total_segments_i),
    .seq_num_i        (seq_num_i),
    .perm_code_i      (perm_code_i),
    .first_char_i     (first_char_i),
    .second_char_i    (second_char_i),
    .done_msg_id_o    (done_msg_id_o),
    .name_char_o      (name_char_o),
    .name_empty_o     (name_empty_o),
    .perm_out_o       (perm_out_o),
    .perm_kind_o      (perm_kind_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

// File: design/mcsr_checker.sv
`default_nettype none
module mcsr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] name_char_o,
  input wire logic       name_empty_o,
  input wire logic [3:0] perm_out_o,
  input wire logic [1:0] perm_kind_o,
  input wire logic       last_o
);
  import mcsr_pkg::*;

  // one word at a time: no input taken while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accepting a word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(name_char_o)
      && $stable(last_o)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && name_empty_o) |-> (last_o && name_char_o == 8'd0))
    else $error("empty name item malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (perm_kind_o == perm_kind_of(perm_out_o)))
    else $error("permission kind mismatch");

endmodule

bind multi_context_segment_reassembler_unit mcsr_checker u_mcsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .name_char_o  (name_char_o),
  .name_empty_o (name_empty_o),
  .perm_out_o   (perm_out_o),
  .perm_kind_o  (perm_kind_o),
  .last_o       (last_o)
);
`default_nettype wire

// File: sim/tb_multi_context_segment_reassembler_unit.sv
`timescale 1ns / 1ps
module tb_multi_context_segment_reassembler_unit;
  import mcsr_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int N_RANDOM     = 89;
  localparam int N_DIRECTED   = 21;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [1:0] id;
    logic [2:0] tot;
    logic [2:0] seq;
    logic [3:0] perm;
    logic [7:0] c1;
    logic [7:0] c2;
  } seg_word_t;

  typedef struct packed {
    logic [1:0] id;
    logic [7:0] ch;
    logic       empty;
    logic [3:0] perm;
    perm_kind_e kind;
    logic       last;
  } name_word_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } chk_mode_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SLOW
  } rx_mode_e;

  typedef struct packed {
    seg_word_t  w;
    chk_mode_e  mode;
    name_word_t res;
  } dir_row_t;

  localparam name_word_t NO_RES = '0;

  localparam dir_row_t DIR_TBL [N_DIRECTED] = '{
    '{'{2'd0, 3'd1, 3'd0, 4'h0, 8'h00, 8'h00}, CHK_ONE,
      '{2'd0, 8'h00, 1'b1, 4'h0, KIND_RO, 1'b1}},
    '{'{2'd1, 3'd1, 3'd0, 4'h1, 8'hff, 8'h00}, CHK_ONE,
      '{2'd1, 8'hff, 1'b0, 4'h1, KIND_RW, 1'b1}},
    '{'{2'd2, 3'd1, 3'd0, 4'hf, 8'h00, 8'h01}, CHK_ONE,
      '{2'd2, 8'h01, 1'b0, 4'hf, KIND_OTHER, 1'b1}},
    // zero total never completes
    '{'{2'd3, 3'd0, 3'd0, 4'h2, 8'h41, 8'h42}, CHK_NONE, NO_RES},
    // repeated position 0 sets the total but keeps the first bytes
    '{'{2'd3, 3'd2, 3'd0, 4'h3, 8'h43, 8'h44}, CHK_MODEL, NO_RES},
    '{'{2'd3, 3'd5, 3'd1, 4'h7, 8'h45, 8'h46}, CHK_MODEL, NO_RES},
    // total of seven with position six missing; position seven counts toward the total but its bytes are not emitted
    '{'{2'd0, 3'd7, 3'd0, 4'h4, 8'h61, 8'h62}, CHK_MODEL, NO_RES},
    '{'{2'd0, 3'd0, 3'd7, 4'h0, 8'h70, 8'h71}, CHK_MODEL, NO_RES},
    '{'{2'd1, 3'd0, 3'd2, 4'h0, 8'h78, 8'h79}, CHK_MODEL, NO_RES},
    '{'{2'd0, 3'd0, 3'd1, 4'h0, 8'h63, 8'h00}, CHK_MODEL, NO_RES},
    '{'{2'd0, 3'd0, 3'd2, 4'h0, 8'h00, 8'h64}, CHK_MODEL, NO_RES},
    '{'{2'd0, 3'd0, 3'd3, 4'h0, 8'h65, 8'h66}, CHK_MODEL, NO_RES},
    '{'{2'd0, 3'd0, 3'd4, 4'h0, 8'h67, 8'h68}, CHK_MODEL, NO_RES},
    // position two lies beyond the total, position one is a hole
    '{'{2'd1, 3'd2, 3'd0, 4'h1, 8'h00, 8'h00}, CHK_ONE,
      '{2'd1, 8'h00, 1'b1, 4'h1, KIND_RW, 1'b1}},
    '{'{2'd0, 3'd0, 3'd5, 4'h0, 8'h69, 8'h6a}, CHK_MODEL, NO_RES},
    '{'{2'd2, 3'd0, 3'd3, 4'h0, 8'haa, 8'hbb}, CHK_MODEL, NO_RES},
    '{'{2'd2, 3'd0, 3'd0, 4'h9, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
    '{'{2'd2, 3'd4, 3'd0, 4'h8, 8'h11, 8'h22}, CHK_MODEL, NO_RES},
    '{'{2'd2, 3'd0, 3'd1, 4'h0, 8'h33, 8'h44}, CHK_MODEL, NO_RES},
    '{'{2'd2, 3'd0, 3'd3, 4'h0, 8'h55, 8'h66}, CHK_MODEL, NO_RES},
    '{'{2'd2, 3'd0, 3'd2, 4'h0, 8'hff, 8'hff}, CHK_MODEL, NO_RES}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       out_ready = 1'b0;
  seg_word_t  drv_w     = '0;

  logic       in_ready;
  logic       out_valid;
  logic [1:0] done_id;
  logic [7:0] name_ch;
  logic       name_empty;
  logic [3:0] perm_o;
  logic [1:0] kind_o;
  logic       last_o;

  logic                    ctx_live [NUM_CONTEXTS];
  logic [2:0]              ctx_tot  [NUM_CONTEXTS];
  logic [3:0]              ctx_perm [NUM_CONTEXTS];
  logic [MAX_SEGMENTS-1:0] ctx_seen [NUM_CONTEXTS];
  logic [3:0]              ctx_cnt  [NUM_CONTEXTS];
  logic [15:0]             seg_mem  [NUM_CONTEXTS][MAX_SEGMENTS];

  name_word_t name_q [$];
  seg_word_t  plan_q [NUM_CONTEXTS][$];

  int       n_err      = 0;
  int       n_words    = 0;
  int       n_bytes    = 0;
  int       n_names    = 0;
  int       burst_left = 0;
  int       idle_cnt   = 0;
  int       rx_left    = 0;
  rx_mode_e rx_mode    = RX_OPEN;

  multi_context_segment_reassembler_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .msg_id_i         (drv_w.id),
    .total_segments_i (drv_w.tot),
    .seq_num_i        (drv_w.seq),
    .perm_code_i      (drv_w.perm),
    .first_char_i     (drv_w.c1),
    .second_char_i    (drv_w.c2),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .done_msg_id_o    (done_id),
    .name_char_o      (name_ch),
    .name_empty_o     (name_empty),
    .perm_out_o       (perm_o),
    .perm_kind_o      (kind_o),
    .last_o           (last_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic absorb_segment(input seg_word_t w, ref name_word_t res_q[$]);
    name_word_t r;
    logic [15:0] seg;
    res_q.delete();
    if (!ctx_live[w.id]) begin
      ctx_live[w.id] = 1'b1;
      ctx_tot[w.id]  = '0;
      ctx_perm[w.id] = '0;
      ctx_seen[w.id] = '0;
      ctx_cnt[w.id]  = '0;
    end
    if (w.seq == 3'd0) begin
      ctx_tot[w.id]  = w.tot;
      ctx_perm[w.id] = w.perm;
    end
    if (int'(w.seq) < MAX_SEGMENTS && !ctx_seen[w.id][w.seq]) begin
      seg_mem[w.id][w.seq]   = {w.c1, w.c2};
      ctx_seen[w.id][w.seq]  = 1'b1;
      ctx_cnt[w.id]          = ctx_cnt[w.id] + 4'd1;
    end
    if (ctx_tot[w.id] != 3'd0 && ctx_cnt[w.id] == {1'b0, ctx_tot[w.id]}) begin
      r.id    = w.id;
      r.perm  = ctx_perm[w.id];
      r.kind  = (r.perm == PERM_READ_ONLY)  ? KIND_RO :
                (r.perm == PERM_READ_WRITE) ? KIND_RW : KIND_OTHER;
      r.empty = 1'b0;
      r.last  = 1'b0;
      for (int s = 0; s < int'(ctx_tot[w.id]); s++) begin
        if (s < MAX_SEGMENTS && ctx_seen[w.id][s]) begin
          seg = seg_mem[w.id][s];
          if (seg[15:8] != 8'd0) begin
            r.ch = seg[15:8];
            res_q.push_back(r);
          end
          if (seg[7:0] != 8'd0) begin
            r.ch = seg[7:0];
            res_q.push_back(r);
          end
        end
      end
      if (res_q.size() == 0) begin
        r.ch    = 8'd0;
        r.empty = 1'b1;
        r.last  = 1'b1;
        res_q.push_back(r);
      end else begin
        res_q[res_q.size()-1].last = 1'b1;
      end
      ctx_live[w.id] = 1'b0;
      ctx_tot[w.id]  = '0;
      ctx_cnt[w.id]  = '0;
      ctx_seen[w.id] = '0;
    end
  endtask

  task automatic send_word(input seg_word_t w, input chk_mode_e mode,
                           input name_word_t typed_res);
    name_word_t got_q [$];
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    drv_w    <= w;
    do @(posedge clk); while (!in_ready);
    absorb_segment(w, got_q);
    case (mode)
      CHK_ONE:  name_q.push_back(typed_res);
      CHK_NONE: ;
      default: begin
        foreach (got_q[k]) name_q.push_back(got_q[k]);
      end
    endcase
    n_words++;
    burst_left--;
    @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    name_word_t e;
    name_word_t g;
    if (rst_n && out_valid && out_ready) begin
      g.id    = done_id;
      g.ch    = name_ch;
      g.empty = name_empty;
      g.perm  = perm_o;
      g.kind  = perm_kind_e'(kind_o);
      g.last  = last_o;
      n_bytes++;
      if (g.last) n_names++;
      if (name_q.size() == 0) begin
        $error("unexpected name word: done_msg_id %0d name_char %0h", g.id, g.ch);
        n_err++;
      end else begin
        e = name_q.pop_front();
        if (g.id !== e.id) begin
          $error("done_msg_id expected %0d got %0d", e.id, g.id);
          n_err++;
        end
        if (g.ch !== e.ch) begin
          $error("name_char expected %0h got %0h", e.ch, g.ch);
          n_err++;
        end
        if (g.empty !== e.empty) begin
          $error("name_empty expected %0b got %0b", e.empty, g.empty);
          n_err++;
        end
        if (g.perm !== e.perm) begin
          $error("perm_out expected %0h got %0h", e.perm, g.perm);
          n_err++;
        end
        if (g.kind !== e.kind) begin
          $error("perm_kind expected %0d got %0d", e.kind, g.kind);
          n_err++;
        end
        if (g.last !== e.last) begin
          $error("last expected %0b got %0b", e.last, g.last);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d name words pending",
                 IDLE_LIMIT, name_q.size());
        $display("FAIL multi_context_segment_reassembler_unit");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    seg_word_t  w;
    logic [27:0] raw;
    int pos [$];
    int n_rand;
    int ctx;
    int tot;
    int j;
    int t;
    for (int c = 0; c < NUM_CONTEXTS; c++) begin
      ctx_live[c] = 1'b0;
      ctx_tot[c]  = '0;
      ctx_perm[c] = '0;
      ctx_seen[c] = '0;
      ctx_cnt[c]  = '0;
      for (int s = 0; s < MAX_SEGMENTS; s++) seg_mem[c][s] = '0;
    end
    n_rand = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(DIR_TBL[i].w, DIR_TBL[i].mode, DIR_TBL[i].res);
    end

    while (n_rand < N_RANDOM) begin
      ctx = $urandom_range(0, NUM_CONTEXTS - 1);
      if ($urandom_range(0, 7) == 0) begin
        raw = 28'($urandom);
        w   = raw;
        send_word(w, CHK_MODEL, NO_RES);
      end else begin
        if (plan_q[ctx].size() == 0) begin
          tot = $urandom_range(1, 7);
          pos.delete();
          for (int i = 0; i < tot; i++) pos.push_back(i);
          for (int i = tot - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            t      = pos[i];
            pos[i] = pos[j];
            pos[j] = t;
          end
          // hole below the total, filled by a position above it
          if (tot > 1 && tot < MAX_SEGMENTS && $urandom_range(0, 4) == 0) begin
            j = $urandom_range(0, tot - 1);
            if (pos[j] != 0) pos[j] = $urandom_range(tot, MAX_SEGMENTS - 1);
          end
          if ($urandom_range(0, 3) == 0) begin
            pos.insert($urandom_range(0, pos.size()), pos[$urandom_range(0, pos.size() - 1)]);
          end
          foreach (pos[k]) begin
            w.id   = 2'(ctx);
            w.seq  = 3'(pos[k]);
            w.tot  = (pos[k] == 0) ? 3'(tot) : 3'($urandom_range(0, 7));
            w.perm = $urandom_range(0, 1) ? 4'($urandom_range(0, 1))
                                          : 4'($urandom_range(0, 15));
            w.c1   = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            w.c2   = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            plan_q[ctx].push_back(w);
          end
        end
        send_word(plan_q[ctx].pop_front(), CHK_MODEL, NO_RES);
      end
      n_rand++;
    end
    in_valid <= 1'b0;

    while (name_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d segment words (%0d directed, %0d random) across %0d contexts",
             n_words, N_DIRECTED, n_rand, NUM_CONTEXTS);
    $display("checked %0d name words in %0d completed names, %0d mismatches",
             n_bytes, n_names, n_err);
    if (n_err == 0) begin
      $display("PASS multi_context_segment_reassembler_unit");
    end else begin
      $display("FAIL multi_context_segment_reassembler_unit");
    end
    $finish;
  end

endmodule
